@@ rtl/core/rmbd_pkg.sv @@
// ----------------------------------------------------------------------------
// Radar moment bin decoder package
// Shared widths, moment type codes, register indexes, the divider side-band
// type and the constant functions that build the KDP power and SQI root tables.
// ----------------------------------------------------------------------------
package rmbd_pkg;

   // Field and port widths.
   localparam int FRAC_BITS = 24;
   localparam int MT_W      = 5;
   localparam int RAW_W     = 16;
   localparam int PV_W      = 48;
   localparam int CSR_AW    = 8;
   localparam int CSR_DW    = 24;
   localparam int NYQ_W     = 24;
   localparam int WL_W      = 16;
   localparam int PRF_W     = 16;

   // Divider geometry. The widest dividend is the 40-bit width product shifted
   // left by the fraction bits.
   localparam int XW         = 40 + FRAC_BITS;
   localparam int DIV_STEP   = 8;
   localparam int DIV_STAGES = (XW + DIV_STEP - 1) / DIV_STEP;
   localparam int XPW        = DIV_STAGES * DIV_STEP;
   localparam int KDP_SH     = 32 - FRAC_BITS;
   localparam int DW         = (WL_W + KDP_SH > 24) ? (WL_W + KDP_SH) : 24;
   localparam int MW         = 48;
   localparam int BV_W       = FRAC_BITS + 1;

   // Table sizes.
   localparam int KDP_ENTRIES  = 127;
   localparam int SQRT_ENTRIES = 254;
   localparam logic [63:0] KDP_BASE = 64'd4518649762;

   // Constant denominators.
   localparam logic [DW-1:0] DEN_ONE   = DW'(1);
   localparam logic [DW-1:0] DEN_REFL  = DW'(2);
   localparam logic [DW-1:0] DEN_VEL   = DW'(127 * 65536);
   localparam logic [DW-1:0] DEN_WIDTH = DW'(10240000);
   localparam logic [DW-1:0] DEN_ZDR   = DW'(16);
   localparam logic [DW-1:0] DEN_HUND  = DW'(100);
   localparam logic [DW-1:0] DEN_RAIN  = DW'(10000);
   localparam logic [DW-1:0] DEN_127   = DW'(127);
   localparam logic [DW-1:0] DEN_16B   = DW'(65535);
   localparam logic [DW-1:0] DEN_15B   = DW'(32767);
   localparam logic [DW-1:0] DEN_LDR   = DW'(5);

   // Moment type codes.
   localparam logic [MT_W-1:0] MT_HEADER = 5'd0;
   localparam logic [MT_W-1:0] MT_DBT    = 5'd1;
   localparam logic [MT_W-1:0] MT_DBZ    = 5'd2;
   localparam logic [MT_W-1:0] MT_VEL    = 5'd3;
   localparam logic [MT_W-1:0] MT_WIDTH  = 5'd4;
   localparam logic [MT_W-1:0] MT_ZDR    = 5'd5;
   localparam logic [MT_W-1:0] MT_DBZC   = 5'd6;
   localparam logic [MT_W-1:0] MT_DBT2   = 5'd7;
   localparam logic [MT_W-1:0] MT_DBZ2   = 5'd8;
   localparam logic [MT_W-1:0] MT_VEL2   = 5'd9;
   localparam logic [MT_W-1:0] MT_WIDTH2 = 5'd10;
   localparam logic [MT_W-1:0] MT_ZDR2   = 5'd11;
   localparam logic [MT_W-1:0] MT_RAIN2  = 5'd12;
   localparam logic [MT_W-1:0] MT_KDP    = 5'd13;
   localparam logic [MT_W-1:0] MT_KDP2   = 5'd14;
   localparam logic [MT_W-1:0] MT_PHIDP  = 5'd15;
   localparam logic [MT_W-1:0] MT_VELC   = 5'd16;
   localparam logic [MT_W-1:0] MT_SQI    = 5'd17;
   localparam logic [MT_W-1:0] MT_RHOHV  = 5'd18;
   localparam logic [MT_W-1:0] MT_RHOHV2 = 5'd19;
   localparam logic [MT_W-1:0] MT_DBZC2  = 5'd20;
   localparam logic [MT_W-1:0] MT_VELC2  = 5'd21;
   localparam logic [MT_W-1:0] MT_SQI2   = 5'd22;
   localparam logic [MT_W-1:0] MT_PHIDP2 = 5'd23;
   localparam logic [MT_W-1:0] MT_LDRH   = 5'd24;
   localparam logic [MT_W-1:0] MT_LDRH2  = 5'd25;
   localparam logic [MT_W-1:0] MT_LDRV   = 5'd26;
   localparam logic [MT_W-1:0] MT_LDRV2  = 5'd27;

   // Configuration register indexes.
   localparam logic [CSR_AW-1:0] CSR_NYQUIST = 8'd0;
   localparam logic [CSR_AW-1:0] CSR_WAVELEN = 8'd1;
   localparam logic [CSR_AW-1:0] CSR_PRF     = 8'd2;
   localparam logic [CSR_AW-1:0] CSR_VOLUME  = 8'd3;

   // Side-band that travels with each item through the divider.
   typedef struct packed {
      logic            nd;
      logic            byp;
      logic            neg;
      logic [BV_W-1:0] bval;
   } side_type;

   // Power table entry: 600^(k/126) with 32 fraction bits, rounded each step.
   function automatic logic [63:0] pow600(input int k);
      logic [63:0] t;
      logic [63:0] chi;
      logic [63:0] clo;
      logic [63:0] s;
      t   = 64'd1 << 32;
      chi = KDP_BASE >> 16;
      clo = KDP_BASE & 64'hFFFF;
      for (int i = 0; i < KDP_ENTRIES; i++) begin
         if (i < k) begin
            s = t * chi + ((t * clo) >> 16);
            t = (s + 64'd32768) >> 16;
         end
      end
      return t;
   endfunction

   // KDP numerator: 25 times the power table entry.
   function automatic logic [MW-1:0] kdp_coef(input int k);
      logic [63:0] p;
      p = pow600(k) * 64'd25;
      return p[MW-1:0];
   endfunction

   // Rounded 2^FRAC_BITS * sqrt(a / 253).
   function automatic logic [BV_W-1:0] sqrt_coef(input int a);
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] one;
      logic [63:0] yy;
      if (a >= 253) begin
         return BV_W'(64'd1 << FRAC_BITS);
      end
      q = 64'd0;
      r = 64'(a);
      for (int i = 0; i < 2 * FRAC_BITS; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= 64'd253) begin
            r = r - 64'd253;
            q = q | 64'd1;
         end
      end
      x   = q;
      res = 64'd0;
      one = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (x >= res + one) begin
            x   = x - (res + one);
            res = (res >> 1) + one;
         end else begin
            res = res >> 1;
         end
         one = one >> 2;
      end
      yy = res * res + res;
      if (q > yy || (q == yy && 64'd4 * r >= 64'd253)) begin
         res = res + 64'd1;
      end
      return res[BV_W-1:0];
   endfunction

endpackage

@@ rtl/core/rmbd_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel interface
// Carries one raw range bin and its moment type with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmbd_req_if;
   logic                       valid;
   logic                       ready;
   logic [rmbd_pkg::MT_W-1:0]  moment_type;
   logic [rmbd_pkg::RAW_W-1:0] raw_value;

   modport source (output valid, output moment_type, output raw_value, input ready);
   modport sink (input valid, input moment_type, input raw_value, output ready);
endinterface

@@ rtl/core/rmbd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel interface
// Carries the decoded physical value and its no-data flag with valid/ready.
// ----------------------------------------------------------------------------
interface rmbd_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [rmbd_pkg::PV_W-1:0] physical_value;
   logic                             no_data;

   modport source (output valid, output physical_value, output no_data, input ready);
   modport sink (input valid, input physical_value, input no_data, output ready);
endinterface

@@ rtl/core/radar_moment_bin_decoder.sv @@
// ----------------------------------------------------------------------------
// Radar moment bin decoder
// Decodes one raw range-bin word of a given moment type into a signed fixed
// point physical value, rounded to nearest, with a no-data flag.
// ----------------------------------------------------------------------------
// The block takes one bin per clock while no stall holds it and returns one
// result per bin, in order. The path is an input register, a decode stage that
// forms the scaled numerator and divisor, a pipelined divider retiring 8
// quotient bits per stage, and a rounding and saturation stage that drives the
// response register. Most values are formed as round(numerator * 2^FRAC_BITS /
// divisor), so the divider depth follows the 40-bit width product plus the
// fraction bits; KDP divides its table entry unshifted and SQI and RHOHV are
// read from a root table. Stalls hold only stages that are occupied, so bubbles
// close up while the response waits. The configuration registers must only be
// written while no transaction is in flight.
module radar_moment_bin_decoder (
   input  logic                       clock,
   input  logic                       reset,
   rmbd_req_if.sink                   req_ch,
   rmbd_rsp_if.source                 rsp_ch,
   input  logic                       csr_we,
   input  logic [rmbd_pkg::CSR_AW-1:0] csr_index,
   input  logic [rmbd_pkg::CSR_DW-1:0] csr_wdata
);
   import rmbd_pkg::*;

   localparam logic [XPW:0] SAT_NEG = (XPW+1)'(1) << (PV_W - 1);
   localparam logic [XPW:0] SAT_POS = SAT_NEG - (XPW+1)'(1);

   // Configuration registers.
   logic [NYQ_W-1:0]       nyq_ff;
   logic [WL_W-1:0]        wl_ff;
   logic [PRF_W-1:0]       prf_ff;
   logic                   vol_ff;
   logic [WL_W+PRF_W-1:0]  wp_ff;

   // Stage one: accepted transaction.
   logic                   s1_vld_ff;
   logic [MT_W-1:0]        mt_ff;
   logic [RAW_W-1:0]       raw_ff;
   logic                   s1_en;

   // Stage two: dividend, divisor and side-band.
   logic                   s2_vld_ff;
   logic [XPW-1:0]         x_ff;
   logic [DW-1:0]          d_ff;
   side_type               side_ff;
   logic                   s2_en;

   // Decode outputs.
   logic [MW-1:0]          mag_in;
   logic [DW-1:0]          den_in;
   logic                   kdp_in;
   side_type               side_in;
   logic [XPW-1:0]         x_in;

   // Tables.
   logic [MW-1:0]          kdp_rom  [KDP_ENTRIES];
   logic [BV_W-1:0]        sqrt_rom [SQRT_ENTRIES];

   // Divider outputs.
   logic                   div_ready;
   logic                   div_vld;
   logic [XPW-1:0]         div_q;
   logic [DW-1:0]          div_r;
   logic [DW-1:0]          div_d;
   side_type               div_side;

   // Response stage.
   logic                   out_vld_ff;
   logic [PV_W-1:0]        pv_ff;
   logic                   nd_ff;
   logic [PV_W-1:0]        pv_in;
   logic                   out_en;

   for (genvar g = 0; g < KDP_ENTRIES; g++) begin : g_kdp
      localparam logic [MW-1:0] C = kdp_coef(g);
      assign kdp_rom[g] = C;
   end

   for (genvar g = 0; g < SQRT_ENTRIES; g++) begin : g_sqrt
      localparam logic [BV_W-1:0] C = sqrt_coef(g);
      assign sqrt_rom[g] = C;
   end

   // Configuration writes; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         nyq_ff <= '0;
         wl_ff  <= '0;
         prf_ff <= '0;
         vol_ff <= 1'b0;
         wp_ff  <= '0;
      end else begin
         wp_ff <= (WL_W+PRF_W)'(wl_ff) * (WL_W+PRF_W)'(prf_ff);
         if (csr_we) begin
            case (csr_index)
               CSR_NYQUIST: nyq_ff <= csr_wdata[NYQ_W-1:0];
               CSR_WAVELEN: wl_ff  <= csr_wdata[WL_W-1:0];
               CSR_PRF:     prf_ff <= csr_wdata[PRF_W-1:0];
               CSR_VOLUME:  vol_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // Stall chain from the response back to the request.
   assign out_en       = !out_vld_ff || rsp_ch.ready;
   assign s2_en        = !s2_vld_ff || div_ready;
   assign s1_en        = !s1_vld_ff || s2_en;
   assign req_ch.ready = s1_en;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (s1_en) begin
         s1_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         mt_ff  <= req_ch.moment_type;
         raw_ff <= req_ch.raw_value;
      end
   end

   // Decode: pick the numerator magnitude, sign and divisor for each type.
   always_comb begin
      logic [7:0]  v8;
      logic [7:0]  a128;
      logic        lt128;
      logic        byte1;
      logic [3:0]  ex;
      logic [27:0] rain;
      logic [6:0]  kidx;
      v8    = raw_ff[7:0];
      lt128 = v8 < 8'd128;
      a128  = lt128 ? (8'd128 - v8) : (v8 - 8'd128);
      byte1 = (raw_ff != '0) && (raw_ff <= 16'd255);
      ex    = raw_ff[15:12];
      rain  = (28'({1'b1, raw_ff[11:0]}) << (ex - 4'd1)) - 28'd1;
      kidx  = (v8 > 8'd128) ? 7'(v8 - 8'd129) : 7'(8'd127 - v8);

      mag_in       = '0;
      den_in       = DEN_ONE;
      kdp_in       = 1'b0;
      side_in.nd   = 1'b1;
      side_in.byp  = 1'b0;
      side_in.neg  = 1'b0;
      side_in.bval = '0;

      case (mt_ff)
         MT_DBT, MT_DBZ, MT_DBZC: begin
            if (raw_ff != '0) begin
               side_in.nd = 1'b0;
               den_in     = DEN_REFL;
               if (raw_ff > 16'd255) begin
                  mag_in = MW'(191);
               end else begin
                  side_in.neg = v8 < 8'd64;
                  mag_in      = MW'(side_in.neg ? (8'd64 - v8) : (v8 - 8'd64));
               end
            end
         end
         MT_VEL: begin
            if (vol_ff && byte1) begin
               side_in.nd  = 1'b0;
               side_in.neg = lt128;
               mag_in      = MW'(32'(nyq_ff) * 32'(a128));
               den_in      = DEN_VEL;
            end
         end
         MT_WIDTH: begin
            if (vol_ff && wl_ff != '0 && byte1) begin
               side_in.nd = 1'b0;
               mag_in     = MW'(40'(wp_ff) * 40'(v8));
               den_in     = DEN_WIDTH;
            end
         end
         MT_ZDR: begin
            if (byte1) begin
               side_in.nd  = 1'b0;
               side_in.neg = lt128;
               mag_in      = MW'(a128);
               den_in      = DEN_ZDR;
            end
         end
         MT_DBT2, MT_DBZ2, MT_VEL2, MT_ZDR2, MT_KDP2, MT_DBZC2, MT_VELC2, MT_LDRH2,
         MT_LDRV2: begin
            if (raw_ff != '0) begin
               side_in.nd  = 1'b0;
               side_in.neg = !raw_ff[15];
               mag_in      = MW'(side_in.neg ? (16'h8000 - raw_ff) : (raw_ff - 16'h8000));
               den_in      = DEN_HUND;
            end
         end
         MT_WIDTH2: begin
            if (raw_ff != '0) begin
               side_in.nd = 1'b0;
               mag_in     = MW'(raw_ff);
               den_in     = DEN_HUND;
            end
         end
         MT_RAIN2: begin
            if (vol_ff && raw_ff != '0) begin
               side_in.nd = 1'b0;
               den_in     = DEN_RAIN;
               if (ex == 4'd0) begin
                  mag_in = MW'(raw_ff[11:0] - 12'd1);
               end else begin
                  mag_in = MW'(rain);
               end
            end
         end
         MT_KDP: begin
            if (vol_ff && wl_ff != '0 && byte1) begin
               side_in.nd = 1'b0;
               if (v8 == 8'd128) begin
                  side_in.byp = 1'b1;
               end else begin
                  side_in.neg = lt128;
                  kdp_in      = 1'b1;
                  mag_in      = kdp_rom[kidx];
                  den_in      = DW'(wl_ff) << KDP_SH;
               end
            end
         end
         MT_PHIDP: begin
            if (byte1) begin
               side_in.nd = 1'b0;
               mag_in     = MW'(16'(v8 - 8'd1) * 16'd90);
               den_in     = DEN_127;
            end
         end
         MT_VELC: begin
            if (byte1) begin
               side_in.nd  = 1'b0;
               side_in.neg = lt128;
               mag_in      = MW'(16'(a128) * 16'd75);
               den_in      = DEN_127;
            end
         end
         MT_SQI, MT_RHOHV: begin
            if (raw_ff != '0 && raw_ff <= 16'd254) begin
               side_in.nd   = 1'b0;
               side_in.byp  = 1'b1;
               side_in.bval = sqrt_rom[v8 - 8'd1];
            end
         end
         MT_RHOHV2, MT_SQI2: begin
            if (raw_ff != '0) begin
               side_in.nd = 1'b0;
               mag_in     = MW'(raw_ff - 16'd1);
               den_in     = DEN_16B;
            end
         end
         MT_PHIDP2: begin
            if (raw_ff != '0) begin
               side_in.nd = 1'b0;
               mag_in     = MW'(24'(raw_ff - 16'd1) * 24'd180);
               den_in     = DEN_15B;
            end
         end
         MT_LDRH, MT_LDRV: begin
            if (byte1) begin
               side_in.nd  = 1'b0;
               side_in.neg = v8 < 8'd226;
               mag_in      = MW'(side_in.neg ? (8'd226 - v8) : (v8 - 8'd226));
               den_in      = DEN_LDR;
            end
         end
         default: ;
      endcase
   end

   // KDP keeps its raw magnitude; all other types scale by the fraction bits.
   assign x_in = kdp_in ? XPW'(mag_in) : (XPW'(mag_in) << FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (s2_en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         x_ff    <= x_in;
         d_ff    <= den_in;
         side_ff <= side_in;
      end
   end

   rmbd_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_vld_ff),
      .in_ready  (div_ready),
      .in_x      (x_ff),
      .in_d      (d_ff),
      .in_side   (side_ff),
      .out_valid (div_vld),
      .out_ready (out_en),
      .out_q     (div_q),
      .out_r     (div_r),
      .out_d     (div_d),
      .out_side  (div_side)
   );

   // Round half away from zero, saturate, sign; bypass and no-data win.
   always_comb begin
      logic          up;
      logic [XPW:0]  total;
      logic [XPW:0]  lim;
      logic [PV_W-1:0] mag;
      up    = {div_r, 1'b0} >= {1'b0, div_d};
      total = {1'b0, div_q} + (XPW+1)'(up);
      lim   = div_side.neg ? SAT_NEG : SAT_POS;
      mag   = (total > lim) ? lim[PV_W-1:0] : total[PV_W-1:0];
      pv_in = div_side.neg ? (PV_W'(0) - mag) : mag;
      if (div_side.byp) begin
         pv_in = PV_W'(div_side.bval);
      end
      if (div_side.nd) begin
         pv_in = '0;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_en) begin
         out_vld_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         pv_ff <= pv_in;
         nd_ff <= div_side.nd;
      end
   end

   assign rsp_ch.valid          = out_vld_ff;
   assign rsp_ch.physical_value = pv_ff;
   assign rsp_ch.no_data        = nd_ff;

endmodule

@@ rtl/core/rmbd_divider.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Divides an unsigned dividend by an unsigned divisor, a fixed number of
// quotient bits per stage, with per-stage valid and a stall that only holds
// occupied stages.
// ----------------------------------------------------------------------------
module rmbd_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [rmbd_pkg::XPW-1:0] in_x,
   input  logic [rmbd_pkg::DW-1:0]  in_d,
   input  rmbd_pkg::side_type       in_side,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [rmbd_pkg::XPW-1:0] out_q,
   output logic [rmbd_pkg::DW-1:0]  out_r,
   output logic [rmbd_pkg::DW-1:0]  out_d,
   output rmbd_pkg::side_type       out_side
);
   import rmbd_pkg::*;

   logic           vld_ff  [DIV_STAGES];
   logic [XPW-1:0] x_ff    [DIV_STAGES];
   logic [DW-1:0]  r_ff    [DIV_STAGES];
   logic [DW-1:0]  d_ff    [DIV_STAGES];
   side_type       side_ff [DIV_STAGES];
   logic           en      [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic           src_vld;
      logic [XPW-1:0] src_x;
      logic [DW-1:0]  src_r;
      logic [DW-1:0]  src_d;
      side_type       src_side;
      logic           nxt_en;
      logic [XPW-1:0] x_in;
      logic [DW-1:0]  r_in;

      // Source of this stage: the input port or the previous stage.
      if (s == 0) begin : g_first
         assign src_vld  = in_valid;
         assign src_x    = in_x;
         assign src_r    = '0;
         assign src_d    = in_d;
         assign src_side = in_side;
      end else begin : g_rest
         assign src_vld  = vld_ff[s-1];
         assign src_x    = x_ff[s-1];
         assign src_r    = r_ff[s-1];
         assign src_d    = d_ff[s-1];
         assign src_side = side_ff[s-1];
      end

      if (s == DIV_STAGES - 1) begin : g_last
         assign nxt_en = out_ready;
      end else begin : g_mid
         assign nxt_en = en[s+1];
      end

      // A stage loads when it is empty or its content moves on.
      assign en[s] = !vld_ff[s] || nxt_en;

      // Restoring steps: quotient bits shift into the dividend register.
      always_comb begin
         logic [DW:0] t;
         x_in = src_x;
         r_in = src_r;
         for (int i = 0; i < DIV_STEP; i++) begin
            t    = {r_in, x_in[XPW-1]};
            x_in = {x_in[XPW-2:0], 1'b0};
            if (t >= {1'b0, src_d}) begin
               t       = t - {1'b0, src_d};
               x_in[0] = 1'b1;
            end
            r_in = t[DW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en[s]) begin
            vld_ff[s] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            x_ff[s]    <= x_in;
            r_ff[s]    <= r_in;
            d_ff[s]    <= src_d;
            side_ff[s] <= src_side;
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_q     = x_ff[DIV_STAGES-1];
   assign out_r     = r_ff[DIV_STAGES-1];
   assign out_d     = d_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule

@@ sim/tb_radar_moment_bin_decoder.sv @@
// ----------------------------------------------------------------------------
// Radar moment bin decoder testbench
// Drives range-bin transactions of every moment type under several register
// settings, predicts each decoded value in fixed point and compares every
// response against it in order, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_radar_moment_bin_decoder;
   import rmbd_pkg::*;

   localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF;
   localparam logic [63:0] OUT_MASK = 64'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [PV_W-1:0] value;
      logic            nd;
   } decoded_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   rmbd_req_if req_ch ();
   rmbd_rsp_if rsp_ch ();

   // Mirror of the configuration registers.
   logic [23:0] nyq_reg;
   logic [15:0] wl_reg;
   logic [15:0] prf_reg;
   logic        vol_reg;

   decoded_type expected_q[$];
   int          err_count = 0;
   logic [63:0] power_rom [0:126];

   radar_moment_bin_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Round mag * 2^sh / den to nearest, ties away from zero, saturated to 48 bits.
   function automatic logic [63:0] round_ratio(logic [63:0] mag, logic [63:0] den,
                                               int sh, bit neg);
      logic [63:0] lim;
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] f;
      logic [63:0] rem;
      logic [63:0] total;
      lim = neg ? POS_MAX + 1 : POS_MAX;
      q   = mag / den;
      r   = mag % den;
      if ((q >> (47 - sh)) != 0) begin
         total = lim;
      end else begin
         f   = (r << sh) / den;
         rem = (r << sh) % den;
         if (2 * rem >= den) f++;
         total = (q << sh) + f;
         if (total > lim) total = lim;
      end
      return neg ? ((64'd0 - total) & OUT_MASK) : total;
   endfunction

   function automatic logic [63:0] scale_signed(longint num, logic [63:0] den);
      bit neg;
      neg = num < 0;
      return round_ratio(neg ? -num : num, den, FRAC_BITS, neg);
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] one;
      res = 0;
      one = 64'd1 << 62;
      while (one > x) one >>= 2;
      while (one != 0) begin
         if (x >= res + one) begin
            x   = x - (res + one);
            res = (res >> 1) + one;
         end else begin
            res = res >> 1;
         end
         one >>= 2;
      end
      return res;
   endfunction

   // Rounded 2^FRAC_BITS * sqrt(a / 253).
   function automatic logic [63:0] root_ratio(logic [63:0] a);
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] y;
      if (a >= 253) return 64'd1 << FRAC_BITS;
      q = 0;
      r = a;
      for (int i = 0; i < 2 * FRAC_BITS; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= 253) begin
            r = r - 253;
            q = q | 1;
         end
      end
      y = int_sqrt(q);
      if (q > y * y + y || (q == y * y + y && 4 * r >= 253)) y++;
      return y;
   endfunction

   // Physical value of one bin under the current register settings.
   function automatic decoded_type decode_bin(logic [MT_W-1:0] mt, logic [15:0] raw);
      decoded_type d;
      longint v;
      bit one_byte;
      logic [63:0] val;
      logic [3:0] e;
      longint m;
      longint num;
      int k;
      v        = raw;
      one_byte = !(v == 0 || v > 255);
      val      = 0;
      d.nd     = 1'b0;
      case (mt)
         MT_DBT, MT_DBZ, MT_DBZC: begin
            if (v == 0) d.nd = 1'b1;
            else val = (v > 255) ? scale_signed(191, 2) : scale_signed(v - 64, 2);
         end
         MT_VEL: begin
            if (!vol_reg || !one_byte) d.nd = 1'b1;
            else val = scale_signed(longint'(nyq_reg) * (v - 128), 127 * 65536);
         end
         MT_WIDTH: begin
            if (!vol_reg || wl_reg == 0 || !one_byte) d.nd = 1'b1;
            else val = round_ratio(64'(wl_reg) * 64'(prf_reg) * 64'(v), 10240000,
                                   FRAC_BITS, 1'b0);
         end
         MT_ZDR: begin
            if (!one_byte) d.nd = 1'b1; else val = scale_signed(v - 128, 16);
         end
         MT_DBT2, MT_DBZ2, MT_VEL2, MT_ZDR2, MT_KDP2, MT_DBZC2, MT_VELC2,
         MT_LDRH2, MT_LDRV2: begin
            if (v == 0) d.nd = 1'b1; else val = scale_signed(v - 32768, 100);
         end
         MT_WIDTH2: begin
            if (v == 0) d.nd = 1'b1; else val = scale_signed(v, 100);
         end
         MT_RAIN2: begin
            if (!vol_reg || v == 0) d.nd = 1'b1;
            else begin
               e   = raw[15:12];
               m   = raw[11:0];
               num = (e == 0) ? m - 1 : (((longint'(4096) | m) << (e - 1)) - 1);
               val = scale_signed(num, 10000);
            end
         end
         MT_KDP: begin
            if (!vol_reg || wl_reg == 0 || !one_byte) d.nd = 1'b1;
            else if (v != 128) begin
               k   = int'((v > 128) ? v - 129 : 127 - v);
               val = round_ratio(25 * power_rom[k], 64'(wl_reg) << (32 - FRAC_BITS),
                                 0, v < 128);
            end
         end
         MT_PHIDP: begin
            if (!one_byte) d.nd = 1'b1; else val = scale_signed(90 * (v - 1), 127);
         end
         MT_VELC: begin
            if (!one_byte) d.nd = 1'b1; else val = scale_signed(75 * (v - 128), 127);
         end
         MT_SQI, MT_RHOHV: begin
            if (v == 0 || v > 254) d.nd = 1'b1; else val = root_ratio(v - 1);
         end
         MT_RHOHV2, MT_SQI2: begin
            if (v == 0) d.nd = 1'b1; else val = scale_signed(v - 1, 65535);
         end
         MT_PHIDP2: begin
            if (v == 0) d.nd = 1'b1; else val = scale_signed(180 * (v - 1), 32767);
         end
         MT_LDRH, MT_LDRV: begin
            if (!one_byte) d.nd = 1'b1; else val = scale_signed(v - 226, 5);
         end
         default: d.nd = 1'b1;
      endcase
      d.value = d.nd ? '0 : val[PV_W-1:0];
      return d;
   endfunction

   // Build the power table once, each step rounded as the hardware does.
   initial begin
      logic [63:0] t;
      logic [63:0] s;
      t = 64'd1 << 32;
      for (int i = 0; i < 127; i++) begin
         power_rom[i] = t;
         s = t * (KDP_BASE >> 16) + ((t * (KDP_BASE & 64'hFFFF)) >> 16);
         t = (s + 64'd32768) >> 16;
      end
   end

   // Send one bin after a random gap and queue its expected value.
   task automatic send_bin(logic [MT_W-1:0] mt, logic [15:0] raw);
      int gap;
      gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.moment_type <= mt;
      req_ch.raw_value   <= raw;
      expected_q.push_back(decode_bin(mt, raw));
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // One register write; the write enable drops again before the mirror is updated.
   task automatic write_csr(logic [CSR_AW-1:0] idx, logic [23:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_NYQUIST: nyq_reg = data;
         CSR_WAVELEN: wl_reg  = data[15:0];
         CSR_PRF:     prf_reg = data[15:0];
         CSR_VOLUME:  vol_reg = data[0];
         default: ;
      endcase
   endtask

   task automatic set_volume(logic [23:0] nyq, logic [15:0] wl, logic [15:0] prf, bit vol);
      drain();
      write_csr(CSR_NYQUIST, nyq);
      write_csr(CSR_WAVELEN, {8'd0, wl});
      write_csr(CSR_PRF, {8'd0, prf});
      write_csr(CSR_VOLUME, {23'd0, vol});
   endtask

   // Field extremes and every third type code with no volume metadata after reset.
   task automatic test_reset_defaults();
      logic [15:0] corner[5] = '{16'd0, 16'd1, 16'd128, 16'd255, 16'hFFFF};
      for (int t = 0; t < 32; t += 3) send_bin(MT_W'(t), corner[t % 5]);
   endtask

   // Directed corners with volume metadata present.
   task automatic test_directed();
      set_volume(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_bin(MT_DBZ, 16'd256);
      send_bin(MT_DBT, 16'd1);
      send_bin(MT_VEL, 16'd1);
      send_bin(MT_VEL, 16'd255);
      send_bin(MT_WIDTH, 16'd255);
      send_bin(MT_KDP, 16'd128);
      send_bin(MT_KDP, 16'd1);
      send_bin(MT_KDP, 16'd255);
      send_bin(MT_RAIN2, 16'hFFFF);
      send_bin(MT_RAIN2, 16'h0001);
      send_bin(MT_SQI, 16'd254);
      send_bin(MT_RHOHV, 16'd255);
      send_bin(MT_PHIDP2, 16'hFFFF);
      send_bin(MT_LDRV, 16'd1);
      send_bin(MT_WIDTH2, 16'hFFFF);
      // Zero wavelength blocks width and KDP.
      set_volume(24'd0, 16'd0, 16'd0, 1'b1);
      send_bin(MT_WIDTH, 16'd100);
      send_bin(MT_KDP, 16'd200);
      send_bin(MT_VEL, 16'd200);
   endtask

   // Random bins under a range of register settings.
   task automatic test_random();
      logic [15:0] raw;
      logic [MT_W-1:0] mt;
      for (int phase = 0; phase < 6; phase++) begin
         set_volume(24'($urandom), 16'($urandom), 16'($urandom), phase != 5);
         // Invalid register index must be ignored.
         write_csr(8'd4 + 8'($urandom_range(0, 251)), 24'($urandom));
         for (int i = 0; i < 110; i++) begin
            mt = MT_W'($urandom_range(0, 31));
            case ($urandom_range(0, 3))
               0: raw = 16'($urandom);
               1: raw = 16'($urandom_range(0, 255));
               2: raw = 16'($urandom_range(0, 3) == 0 ? 0 : 255 + $urandom_range(0, 2));
               default: raw = 16'($urandom_range(1, 254));
            endcase
            send_bin(mt, raw);
         end
      end
   endtask

   // Response side: a random wait before each transaction and in-order comparison.
   initial begin
      decoded_type exp_d;
      int          wait_cycles;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      wait_cycles = $urandom_range(0, 19);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response value %h no_data %b", $time,
                        rsp_ch.physical_value, rsp_ch.no_data);
               err_count++;
            end else begin
               exp_d = expected_q.pop_front();
               if (rsp_ch.physical_value !== exp_d.value) begin
                  $display("%0t: physical_value expected %h actual %h", $time,
                           exp_d.value, rsp_ch.physical_value);
                  err_count++;
               end
               if (rsp_ch.no_data !== exp_d.nd) begin
                  $display("%0t: no_data expected %b actual %b", $time,
                           exp_d.nd, rsp_ch.no_data);
                  err_count++;
               end
            end
            wait_cycles = $urandom_range(0, 19);
         end else if (wait_cycles > 0) begin
            wait_cycles--;
         end
         rsp_ch.ready <= (wait_cycles == 0);
      end
   end

   // Main sequence.
   initial begin
      req_ch.valid       = 1'b0;
      req_ch.moment_type = '0;
      req_ch.raw_value   = '0;
      nyq_reg = '0;
      wl_reg  = '0;
      prf_reg = '0;
      vol_reg = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed();
      test_random();
      drain();
      if (err_count == 0) begin
         $display("tb_radar_moment_bin_decoder passed");
      end else begin
         $display("tb_radar_moment_bin_decoder failed");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #4000000;
      $display("tb_radar_moment_bin_decoder failed");
      $finish;
   end

endmodule
